// File: src/mpmd_pkg.sv
// mpmd_pkg: shared types, constants and register codes for the motor direction control unit
// no dependencies; imported by every module under src

package mpmd_pkg;

   // elapsed counter width, default for the top level parameter
   localparam int ELAPSED_WIDTH_DEF = 11;

   // configuration register widths and port shape
   localparam int DEBOUNCE_W  = 10;
   localparam int TIMEOUT_W   = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT  = 1'd1;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 11'd500;

   // press tally
   localparam int               TALLY_W     = 4;
   localparam logic [TALLY_W-1:0] TALLY_MAX   = 4'd15;
   localparam logic [TALLY_W-1:0] CLICKS_FWD  = 4'd2;
   localparam logic [TALLY_W-1:0] CLICKS_BACK = 4'd3;

   typedef enum logic [1:0] {
      MODE_STOP = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_BACK = 2'd2
   } mode_type;

   // one result beat
   typedef struct packed {
      logic               motor1_fwd_pin;
      logic               motor1_rev_pin;
      logic               motor2_fwd_pin;
      logic               motor2_rev_pin;
      logic [1:0]         drive_mode;
      logic               debounced_level;
      logic [TALLY_W-1:0] presses_pending;
   } result_type;

   // handshake status passed from the input register to the core and result register
   typedef struct packed {
      logic advance;   // input register hands its beat on this cycle
   } flow_type;

endpackage

// File: src/mpmd_in_reg.sv
// mpmd_in_reg: input register holding one button sample beat
// depends on mpmd_pkg (flow_type)

module mpmd_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_button_raw,
   input  logic               out_free,
   output mpmd_pkg::flow_type flow,
   output logic               raw
);
   import mpmd_pkg::*;

   logic valid_ff;
   logic valid_in;
   logic raw_ff;
   logic raw_in;
   logic take;

   always_comb begin
      flow.advance = valid_ff && out_free;
      req_ready    = !valid_ff || flow.advance;
      take         = req_valid && req_ready;
      valid_in     = take || (valid_ff && !flow.advance);
      raw_in       = take ? req_button_raw : raw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      raw_ff <= raw_in;
   end

   assign raw = raw_ff;

endmodule

// File: src/mpmd_core.sv
// mpmd_core: configuration registers, debounce and press state, next-state logic
// depends on mpmd_pkg (widths, codes, mode_type, result_type)

module mpmd_core #(
   parameter int ELAPSED_WIDTH = mpmd_pkg::ELAPSED_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [mpmd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mpmd_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               step,
   input  logic                               raw,
   output mpmd_pkg::result_type               result
);
   import mpmd_pkg::*;

   localparam int CMP_W = (ELAPSED_WIDTH > TIMEOUT_W) ? ELAPSED_WIDTH : TIMEOUT_W;
   localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

   logic [DEBOUNCE_W-1:0]    debounce_ff;
   logic [TIMEOUT_W-1:0]     timeout_ff;
   logic                     prev_ff;
   logic                     stable_ff;
   logic                     stable_in;
   logic [ELAPSED_WIDTH-1:0] elapsed_ff;
   logic [ELAPSED_WIDTH-1:0] elapsed_run;
   logic [ELAPSED_WIDTH-1:0] elapsed_in;
   logic [TALLY_W-1:0]       tally_ff;
   logic [TALLY_W-1:0]       tally_pressed;
   logic [TALLY_W-1:0]       tally_in;
   mode_type                 motion_ff;
   mode_type                 motion_rel;
   mode_type                 motion_in;
   logic                     debounce_hit;
   logic                     timeout_hit;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_write_data[DEBOUNCE_W-1:0];
            CSR_TIMEOUT:  timeout_ff  <= csr_write_data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // elapsed counter, debounce and press judgement
   always_comb begin
      if (raw != prev_ff) begin
         elapsed_run = '0;
      end else if (elapsed_ff != ELAPSED_MAX) begin
         elapsed_run = elapsed_ff + 1'b1;
      end else begin
         elapsed_run = elapsed_ff;
      end

      debounce_hit = (CMP_W'(elapsed_run) > CMP_W'(debounce_ff)) && (raw != stable_ff);

      stable_in     = stable_ff;
      elapsed_in    = elapsed_run;
      tally_pressed = tally_ff;
      motion_rel    = motion_ff;
      if (debounce_hit) begin
         stable_in = raw;
         if (!raw) begin
            if (tally_ff != TALLY_MAX) begin
               tally_pressed = tally_ff + 1'b1;
            end
            elapsed_in = '0;
         end else begin
            motion_rel = MODE_STOP;
         end
      end

      timeout_hit = CMP_W'(elapsed_in) > CMP_W'(timeout_ff);

      tally_in  = tally_pressed;
      motion_in = motion_rel;
      if (timeout_hit) begin
         if (motion_rel == MODE_STOP) begin
            if (tally_pressed == CLICKS_FWD) begin
               motion_in = MODE_FWD;
            end else if (tally_pressed == CLICKS_BACK) begin
               motion_in = MODE_BACK;
            end
         end
         tally_in = '0;
      end

      // both bridges driven alike
      result.motor1_fwd_pin  = (motion_in == MODE_FWD);
      result.motor1_rev_pin  = (motion_in == MODE_BACK);
      result.motor2_fwd_pin  = (motion_in == MODE_FWD);
      result.motor2_rev_pin  = (motion_in == MODE_BACK);
      result.drive_mode      = motion_in;
      result.debounced_level = stable_in;
      result.presses_pending = tally_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b0;
         stable_ff  <= 1'b0;
         elapsed_ff <= '0;
         tally_ff   <= '0;
         motion_ff  <= MODE_STOP;
      end else if (step) begin
         prev_ff    <= raw;
         stable_ff  <= stable_in;
         elapsed_ff <= elapsed_in;
         tally_ff   <= tally_in;
         motion_ff  <= motion_in;
      end
   end

   // drive starts only from a judged tally of two or three
   a_start_from_tally : assert property (@(posedge clock) disable iff (reset)
      (step && motion_ff == MODE_STOP && motion_in != MODE_STOP)
         |-> (tally_ff == CLICKS_FWD || tally_ff == CLICKS_BACK))
      else $error("drive started without a valid press tally");

   // a running drive never switches direction directly
   a_no_reversal : assert property (@(posedge clock) disable iff (reset)
      (step && motion_ff != MODE_STOP && motion_in != MODE_STOP)
         |-> (motion_in == motion_ff))
      else $error("drive changed direction without stopping");

   // the stable level only moves on a sample equal to the previous one
   a_stable_needs_hold : assert property (@(posedge clock) disable iff (reset)
      (step && stable_in != stable_ff) |-> (raw == prev_ff))
      else $error("stable level changed on a raw edge");

   // tally only steps up by one or clears
   a_tally_step : assert property (@(posedge clock) disable iff (reset)
      (step && tally_in != tally_ff)
         |-> (tally_in == '0 || tally_in == tally_ff + 1'b1))
      else $error("press tally moved by more than one");

endmodule

// File: src/mpmd_out_reg.sv
// mpmd_out_reg: result register for the motor pin beat
// depends on mpmd_pkg (result_type)

module mpmd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mpmd_pkg::result_type result,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_motor1_fwd_pin,
   output logic                 rsp_motor1_rev_pin,
   output logic                 rsp_motor2_fwd_pin,
   output logic                 rsp_motor2_rev_pin,
   output logic [1:0]           rsp_drive_mode,
   output logic                 rsp_debounced_level,
   output logic [mpmd_pkg::TALLY_W-1:0] rsp_presses_pending
);
   import mpmd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;
   result_type data_in;

   always_comb begin
      free     = !valid_ff || rsp_ready;
      valid_in = load || (valid_ff && !rsp_ready);
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_motor1_fwd_pin  = data_ff.motor1_fwd_pin;
   assign rsp_motor1_rev_pin  = data_ff.motor1_rev_pin;
   assign rsp_motor2_fwd_pin  = data_ff.motor2_fwd_pin;
   assign rsp_motor2_rev_pin  = data_ff.motor2_rev_pin;
   assign rsp_drive_mode      = data_ff.drive_mode;
   assign rsp_debounced_level = data_ff.debounced_level;
   assign rsp_presses_pending = data_ff.presses_pending;

endmodule

// File: src/multi_press_motor_direction_control_unit.sv
// multi_press_motor_direction_control_unit: top level of the debounced multi-press motor control
// depends on mpmd_pkg, mpmd_in_reg, mpmd_core, mpmd_out_reg
//
//  channel | direction | handshake          | beat contents
//  req_    | in        | req_valid/ready    | button_raw, one sample per tick
//  rsp_    | out       | rsp_valid/ready    | four bridge pins, drive_mode, level, tally
//  csr_    | in        | csr_write_enable   | register index and write data, no read-back
//
// one result beat per request beat, one beat per cycle sustained while rsp_ready stays high
// a beat passes the input register, then the state update into the result register
// the state update is a single pass of compares and counter steps, no iteration
// reset (synchronous, active high) empties both registers and restores register defaults
// a stalled result holds the result register; the input register still takes one more beat

module multi_press_motor_direction_control_unit #(
   parameter int ELAPSED_WIDTH = mpmd_pkg::ELAPSED_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_button_raw,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_motor1_fwd_pin,
   output logic                             rsp_motor1_rev_pin,
   output logic                             rsp_motor2_fwd_pin,
   output logic                             rsp_motor2_rev_pin,
   output logic [1:0]                       rsp_drive_mode,
   output logic                             rsp_debounced_level,
   output logic [mpmd_pkg::TALLY_W-1:0]     rsp_presses_pending,
   // configuration port
   input  logic                             csr_write_enable,
   input  logic [mpmd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mpmd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import mpmd_pkg::*;

   flow_type   flow;      // advance status between the two registers
   logic       out_free;  // result register can accept a beat
   logic       raw;       // registered button sample
   result_type result;    // next-state view of the beat being processed

   // input register: skid point so a new sample lands while the result waits
   mpmd_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_button_raw (req_button_raw),
      .out_free       (out_free),
      .flow           (flow),
      .raw            (raw)
   );

   // state commits only when the beat moves into the result register
   mpmd_core #(
      .ELAPSED_WIDTH (ELAPSED_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step             (flow.advance),
      .raw              (raw),
      .result           (result)
   );

   // result register drives the bridge pins and status
   mpmd_out_reg u_out_reg (
      .clock               (clock),
      .reset               (reset),
      .load                (flow.advance),
      .result              (result),
      .free                (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_motor1_fwd_pin  (rsp_motor1_fwd_pin),
      .rsp_motor1_rev_pin  (rsp_motor1_rev_pin),
      .rsp_motor2_fwd_pin  (rsp_motor2_fwd_pin),
      .rsp_motor2_rev_pin  (rsp_motor2_rev_pin),
      .rsp_drive_mode      (rsp_drive_mode),
      .rsp_debounced_level (rsp_debounced_level),
      .rsp_presses_pending (rsp_presses_pending)
   );

endmodule
